[rtl/lzss_stream_decoder_defines.svh]
// Assertion macros used by the top-level decoder RTL.
`ifndef LZSS_STREAM_DECODER_DEFINES_SVH
`define LZSS_STREAM_DECODER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LZSS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LZSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/lzss_pkg.sv]
package lzss_pkg;

   localparam int BYTE_W          = 8;
   localparam int TOKEN_W         = 16;
   localparam int STORE_W         = 24;
   localparam int CNT_W           = 5;
   localparam int LIT_BITS        = 9;
   localparam int MATCH_BITS      = 17;
   localparam int LENGTH_BITS     = 3;
   localparam int LEN_W           = 4;
   localparam int HIST_DEPTH      = 8192;
   localparam int ADDR_W          = 13;
   localparam int DIST_W          = 14;
   localparam int WINDOW_SIZE_DEF = 8192;
   localparam int MIN_MATCH_DEF   = 3;
   localparam int CMD_DEPTH_DEF   = 4;
   localparam int RSP_DEPTH_DEF   = 4;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_LIT,
      CMD_MATCH
   } lzss_kind_type;

   typedef struct packed {
      lzss_kind_type        kind;
      logic [TOKEN_W-1:0]   payload;
      logic                 stream_end;
   } lzss_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_COPY
   } lzss_state_type;

endpackage

[rtl/lzss_stream_decoder.sv]
// LZSS stream decoder. Compressed bytes go in through a queue-style port (push/full) and
// decoded bytes come out through another (empty/pop); rsp_out_last marks the last byte
// decoded from one input byte. A front unpacker takes one compressed byte per cycle while
// its command queue has room; it completes at most one literal or match per byte. The
// back engine then writes out a literal, pops a dropped match (source before the start of
// the stream) or a byte that completes nothing, and copies a match of 3 to 10 bytes through
// ST_PRIME and ST_COPY, one byte per cycle while the result queue has room, via the single
// read port of the 8 KiB history RAM. Overlapping copies are supported. The history needs no
// clearing after reset; the byte flagged req_in_last ends the stream and empties the window.
`include "lzss_stream_decoder_defines.svh"

module lzss_stream_decoder #(
   parameter int WINDOW_SIZE = lzss_pkg::WINDOW_SIZE_DEF,
   parameter int MIN_MATCH   = lzss_pkg::MIN_MATCH_DEF,
   parameter int CMD_DEPTH   = lzss_pkg::CMD_DEPTH_DEF,
   parameter int RSP_DEPTH   = lzss_pkg::RSP_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic [lzss_pkg::BYTE_W-1:0] req_in_byte,
   input  logic                        req_in_last,
   output logic                        empty,
   input  logic                        pop,
   output logic [lzss_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                        rsp_out_last
);

   import lzss_pkg::*;

   localparam int CMD_W = $bits(lzss_cmd_type);
   localparam int RSP_W = BYTE_W + 1;

   lzss_cmd_type       front_cmd;
   lzss_cmd_type       back_cmd;
   logic [CMD_W-1:0]   back_cmd_bits;
   logic               cmd_push;
   logic               cmd_full;
   logic               cmd_empty;
   logic               cmd_pop;
   logic               out_push;
   logic               out_full;
   logic [BYTE_W-1:0]  out_byte;
   logic               out_last;
   logic [RSP_W-1:0]   rsp_bits;

   lzss_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .in_byte  (req_in_byte),
      .in_last  (req_in_last),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd      (front_cmd)
   );

   lzss_fifo #(
      .DATA_WIDTH (CMD_W),
      .DEPTH      (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (front_cmd),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .rd_data (back_cmd_bits)
   );

   assign back_cmd = lzss_cmd_type'(back_cmd_bits);

   lzss_back #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .MIN_MATCH   (MIN_MATCH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd       (back_cmd),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_byte  (out_byte),
      .out_last  (out_last)
   );

   lzss_fifo #(
      .DATA_WIDTH (RSP_W),
      .DEPTH      (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data ({out_last, out_byte}),
      .full    (out_full),
      .pop     (pop),
      .empty   (empty),
      .rd_data (rsp_bits)
   );

   assign rsp_out_byte = rsp_bits[BYTE_W-1:0];
   assign rsp_out_last = rsp_bits[BYTE_W];

   `LZSS_ASSERT_SAME(a_cmd_push_room, clock, reset, cmd_push, !cmd_full, "command queue overrun")
   `LZSS_ASSERT_SAME(a_out_push_room, clock, reset, out_push, !out_full, "result queue overrun")
   `LZSS_ASSERT_NEXT(a_end_queued, clock, reset, push && !full && req_in_last, !cmd_empty, "stream end not queued")

endmodule

[rtl/lzss_fifo.sv]
module lzss_fifo #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] wr_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output logic [DATA_WIDTH-1:0] rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/lzss_front.sv]
module lzss_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic [lzss_pkg::BYTE_W-1:0] in_byte,
   input  logic                        in_last,
   input  logic                        cmd_full,
   output logic                        cmd_push,
   output lzss_pkg::lzss_cmd_type      cmd
);

   import lzss_pkg::*;

   logic [STORE_W-1:0] store_ff, store_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [STORE_W-1:0] store_cat;
   logic [STORE_W-1:0] shifted;
   logic [CNT_W-1:0]   count_cat;
   logic [CNT_W-1:0]   need;
   logic [CNT_W-1:0]   shamt;
   logic               flag;
   logic               done;
   logic               accept;

   assign full   = cmd_full;
   assign accept = push && !cmd_full;

   always_comb begin
      store_cat = {store_ff[STORE_W-BYTE_W-1:0], in_byte};
      count_cat = count_ff + CNT_W'(BYTE_W);
      flag      = store_cat[count_cat - CNT_W'(1)];
      need      = flag ? CNT_W'(MATCH_BITS) : CNT_W'(LIT_BITS);
      done      = (count_cat >= need);
      shamt     = count_cat - need;
      shifted   = store_cat >> shamt;

      cmd.stream_end = in_last;
      if (!done) begin
         cmd.kind    = CMD_NONE;
         cmd.payload = '0;
      end else if (flag) begin
         cmd.kind    = CMD_MATCH;
         cmd.payload = shifted[TOKEN_W-1:0];
      end else begin
         cmd.kind    = CMD_LIT;
         cmd.payload = {{(TOKEN_W-BYTE_W){1'b0}}, shifted[BYTE_W-1:0]};
      end
      cmd_push = accept && (done || in_last);

      store_in = store_ff;
      count_in = count_ff;
      if (accept) begin
         if (in_last) begin
            store_in = '0;
            count_in = '0;
         end else begin
            store_in = store_cat;
            count_in = done ? shamt : count_cat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         count_ff <= '0;
      end else begin
         store_ff <= store_in;
         count_ff <= count_in;
      end
   end

endmodule

[rtl/lzss_back.sv]
module lzss_back #(
   parameter int WINDOW_SIZE = lzss_pkg::WINDOW_SIZE_DEF,
   parameter int MIN_MATCH   = lzss_pkg::MIN_MATCH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   input  lzss_pkg::lzss_cmd_type      cmd,
   output logic                        cmd_pop,
   input  logic                        out_full,
   output logic                        out_push,
   output logic [lzss_pkg::BYTE_W-1:0] out_byte,
   output logic                        out_last
);

   import lzss_pkg::*;

   localparam int                 FILL_W   = $clog2(WINDOW_SIZE + 1);
   localparam logic [DIST_W-1:0]  WIN      = DIST_W'(WINDOW_SIZE);
   localparam logic [FILL_W-1:0]  FILL_MAX = FILL_W'(WINDOW_SIZE);

   logic [BYTE_W-1:0]  hist [HIST_DEPTH];

   lzss_state_type     state_ff, state_in;
   logic [ADDR_W-1:0]  wp_ff, wp_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [BYTE_W-1:0]  last_ff, last_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic [LEN_W-1:0]   remain_ff, remain_in;
   logic               end_ff, end_in;
   logic [BYTE_W-1:0]  rd_data_ff;

   logic [ADDR_W-1:0]  tok_off;
   logic [LEN_W-1:0]   tok_len;
   logic [DIST_W-1:0]  tok_dist;
   logic               tok_ok;
   logic [BYTE_W-1:0]  copy_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic               we;
   logic [BYTE_W-1:0]  wdata;
   logic               advance;
   logic               finish_end;

   always_comb begin
      tok_off   = cmd.payload[TOKEN_W-1:LENGTH_BITS];
      tok_len   = {1'b0, cmd.payload[LENGTH_BITS-1:0]} + LEN_W'(MIN_MATCH);
      tok_dist  = WIN - {1'b0, tok_off};
      tok_ok    = ({1'b0, tok_off} < WIN) && (tok_dist <= DIST_W'(fill_ff));
      copy_data = (dist_ff == DIST_W'(1)) ? last_ff : rd_data_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && (cmd.kind == CMD_MATCH) && tok_ok) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            state_in = ST_COPY;
         end
         ST_COPY: begin
            if (!out_full && (remain_ff == LEN_W'(1))) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_pop    = 1'b0;
      out_push   = 1'b0;
      out_byte   = copy_data;
      out_last   = 1'b0;
      we         = 1'b0;
      wdata      = copy_data;
      rd_en      = 1'b0;
      rd_addr    = wp_ff - dist_ff[ADDR_W-1:0];
      advance    = 1'b0;
      finish_end = 1'b0;
      dist_in    = dist_ff;
      remain_in  = remain_ff;
      end_in     = end_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  CMD_LIT: begin
                     if (!out_full) begin
                        cmd_pop    = 1'b1;
                        out_push   = 1'b1;
                        out_byte   = cmd.payload[BYTE_W-1:0];
                        out_last   = 1'b1;
                        we         = 1'b1;
                        wdata      = cmd.payload[BYTE_W-1:0];
                        advance    = 1'b1;
                        finish_end = cmd.stream_end;
                     end
                  end
                  CMD_MATCH: begin
                     cmd_pop = 1'b1;
                     if (tok_ok) begin
                        dist_in   = tok_dist;
                        remain_in = tok_len;
                        end_in    = cmd.stream_end;
                     end else begin
                        finish_end = cmd.stream_end;
                     end
                  end
                  default: begin
                     cmd_pop    = 1'b1;
                     finish_end = cmd.stream_end;
                  end
               endcase
            end
         end
         ST_PRIME: begin
            rd_en = 1'b1;
         end
         ST_COPY: begin
            if (!out_full) begin
               out_push   = 1'b1;
               out_last   = (remain_ff == LEN_W'(1));
               we         = 1'b1;
               advance    = 1'b1;
               remain_in  = remain_ff - LEN_W'(1);
               rd_en      = 1'b1;
               rd_addr    = wp_ff + ADDR_W'(1) - dist_ff[ADDR_W-1:0];
               finish_end = end_ff && (remain_ff == LEN_W'(1));
            end
         end
         default: begin
         end
      endcase

      wp_in   = wp_ff;
      fill_in = fill_ff;
      last_in = last_ff;
      if (advance) begin
         wp_in   = wp_ff + ADDR_W'(1);
         fill_in = (fill_ff == FILL_MAX) ? fill_ff : fill_ff + FILL_W'(1);
         last_in = wdata;
      end
      if (finish_end) begin
         wp_in   = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wp_ff    <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff   <= last_in;
      dist_ff   <= dist_in;
      remain_ff <= remain_in;
      end_ff    <= end_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         hist[wp_ff] <= wdata;
      end
      if (rd_en) begin
         rd_data_ff <= hist[rd_addr];
      end
   end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import lzss_pkg::*;

   localparam logic FLAG_LIT   = 1'b0;
   localparam logic FLAG_MATCH = 1'b1;
   localparam int   HOLD_CYCLES = 300;
   localparam int   DRAIN_CYCLES = 40;

   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              last;
   } decoded_beat_type;

   class decode_tracker;
      logic [BYTE_W-1:0]  history [HIST_DEPTH];
      logic [STORE_W-1:0] bit_store;
      logic [CNT_W-1:0]   bit_count;
      logic [ADDR_W-1:0]  wr_ptr;
      logic [DIST_W-1:0]  fill;
      decoded_beat_type   due [$];
      decoded_beat_type   fresh [$];
      int                 errors;
      int                 checked;

      function new();
         bit_store = '0;
         bit_count = '0;
         wr_ptr    = '0;
         fill      = '0;
         errors    = 0;
         checked   = 0;
      endfunction

      function void emit_byte(logic [BYTE_W-1:0] b);
         decoded_beat_type beat;
         beat.data = b;
         beat.last = 1'b0;
         fresh.insert(fresh.size(), beat);
         history[wr_ptr] = b;
         wr_ptr++;
         if (fill < WINDOW_SIZE_DEF) fill++;
      endfunction

      function void copy_match(logic [TOKEN_W-1:0] token);
         int                len;
         int                off;
         int                span;
         logic [ADDR_W-1:0] src;
         len = int'(token[LENGTH_BITS-1:0]) + MIN_MATCH_DEF;
         off = int'(token[TOKEN_W-1:LENGTH_BITS]);
         // drop matches reaching outside the current stream
         if (off >= WINDOW_SIZE_DEF) return;
         span = WINDOW_SIZE_DEF - off;
         if (span > fill) return;
         for (int k = 0; k < len; k++) begin
            src = wr_ptr - ADDR_W'(span);
            emit_byte(history[src]);
         end
      endfunction

      function void absorb_byte(logic [BYTE_W-1:0] b, logic l);
         logic               flag;
         int                 need;
         logic [STORE_W-1:0] part;
         fresh.delete();
         bit_store = {bit_store[STORE_W-BYTE_W-1:0], b};
         bit_count = bit_count + CNT_W'(BYTE_W);
         while (bit_count >= 1) begin
            flag = bit_store[bit_count-1];
            need = (flag == FLAG_MATCH) ? MATCH_BITS : LIT_BITS;
            if (bit_count < need) break;
            part = bit_store >> (bit_count - need);
            bit_count = bit_count - CNT_W'(need);
            bit_store &= (STORE_W'(1) << bit_count) - STORE_W'(1);
            if (flag == FLAG_MATCH) copy_match(part[TOKEN_W-1:0]);
            else emit_byte(part[BYTE_W-1:0]);
         end
         if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
         foreach (fresh[i]) due.insert(due.size(), fresh[i]);
         // end of stream: drop leftover bits, empty the window
         if (l) begin
            bit_store = '0;
            bit_count = '0;
            wr_ptr    = '0;
            fill      = '0;
         end
      endfunction

      function void check_byte(logic [BYTE_W-1:0] b, logic l);
         decoded_beat_type want;
         if (due.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, actual data=%02h last=%b",
                     $time, b, l);
            return;
         end
         want = due.pop_front();
         checked++;
         if (b !== want.data) begin
            errors++;
            $display("%0t: rsp_out_byte mismatch, expected %02h, actual %02h",
                     $time, want.data, b);
         end
         if (l !== want.last) begin
            errors++;
            $display("%0t: rsp_out_last mismatch, expected %b, actual %b",
                     $time, want.last, l);
         end
      endfunction

      function int waiting();
         return due.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              push;
   logic              full;
   logic [BYTE_W-1:0] req_in_byte;
   logic              req_in_last;
   logic              empty;
   logic              pop;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_out_last;

   decode_tracker tracker;
   logic          stream_bits [$];
   int            gen_fill;
   int            n_beats;
   int            n_streams;
   int            full_stalls;
   bit            calm;
   bit            held;

   lzss_stream_decoder dut (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .empty        (empty),
      .pop          (pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void put_bits(int value, int width);
      for (int i = width - 1; i >= 0; i--) stream_bits.insert(stream_bits.size(), value[i]);
   endfunction

   function automatic void add_literal(logic [BYTE_W-1:0] b);
      put_bits(int'(FLAG_LIT), 1);
      put_bits(int'(b), BYTE_W);
      gen_fill++;
   endfunction

   function automatic void add_match(int off, int code);
      put_bits(int'(FLAG_MATCH), 1);
      put_bits(off, ADDR_W);
      put_bits(code, LENGTH_BITS);
      if (WINDOW_SIZE_DEF - off <= gen_fill) gen_fill += code + MIN_MATCH_DEF;
   endfunction

   task automatic send_beat(logic [BYTE_W-1:0] b, logic l);
      req_in_byte <= b;
      req_in_last <= l;
      push        <= 1'b1;
      @(posedge clock);
      while (full) begin
         full_stalls++;
         @(posedge clock);
      end
      tracker.absorb_byte(b, l);
      n_beats++;
      if (!calm && $urandom_range(0, 4) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic send_stream();
      logic [BYTE_W-1:0] b;
      while (stream_bits.size() % BYTE_W != 0)
         stream_bits.insert(stream_bits.size(), 1'($urandom_range(0, 1)));
      while (stream_bits.size() > 0) begin
         for (int i = BYTE_W - 1; i >= 0; i--) b[i] = stream_bits.pop_front();
         send_beat(b, stream_bits.size() == 0);
      end
      gen_fill = 0;
      n_streams++;
   endtask

   task automatic run_sender();
      int directed_beats;
      int n_items;
      int span;
      // back-references, overlap, dropped matches, item ending on the last bit
      add_literal(8'h00);
      add_literal(8'hFF);
      add_match(WINDOW_SIZE_DEF - 1, 7);
      add_match(WINDOW_SIZE_DEF - 2, 0);
      add_match(0, 5);
      add_match(WINDOW_SIZE_DEF - 100, 3);
      add_literal(8'hA5);
      add_match(WINDOW_SIZE_DEF - 3, 7);
      send_stream();
      // partial match left over at stream end
      add_literal(8'h5A);
      put_bits(int'(FLAG_MATCH), 1);
      put_bits(int'(4'b1011), 4);
      send_stream();
      send_beat(8'hFF, 1'b1);
      n_streams++;
      // match before any output
      add_match(WINDOW_SIZE_DEF - 1, 2);
      add_literal(8'h33);
      send_stream();
      directed_beats = n_beats;

      while (n_beats < directed_beats + 95) begin
         if (n_beats >= directed_beats + 75) calm = 1'b1;
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) put_bits($urandom, BYTE_W);
            send_stream();
         end else begin
            n_items = $urandom_range(2, 14);
            repeat (n_items) begin
               if (gen_fill == 0 || $urandom_range(0, 9) < 4) begin
                  add_literal(8'($urandom_range(0, 255)));
               end else if ($urandom_range(0, 9) < 8) begin
                  if ($urandom_range(0, 1) != 0)
                     span = $urandom_range(1, (gen_fill < 4) ? gen_fill : 4);
                  else
                     span = $urandom_range(1, gen_fill);
                  add_match(WINDOW_SIZE_DEF - span, $urandom_range(0, 7));
               end else begin
                  add_match($urandom_range(0, WINDOW_SIZE_DEF - gen_fill - 1),
                            $urandom_range(0, 7));
               end
            end
            // truncate the stream in the middle of a match
            if ($urandom_range(0, 3) == 0) begin
               put_bits(int'(FLAG_MATCH), 1);
               put_bits($urandom, $urandom_range(0, 14));
            end
            send_stream();
         end
      end
      push <= 1'b0;
   endtask

   task automatic run_receiver();
      int gap;
      forever begin
         gap = 0;
         if (!held && tracker.checked >= 15) begin
            held = 1'b1;
            gap  = HOLD_CYCLES;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
         end
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         if (pop && !empty) tracker.check_byte(rsp_out_byte, rsp_out_last);
      end
   endtask

   initial begin
      tracker     = new();
      reset       = 1'b1;
      push        = 1'b0;
      pop         = 1'b0;
      req_in_byte = '0;
      req_in_last = 1'b0;
      gen_fill    = 0;
      n_beats     = 0;
      n_streams   = 0;
      full_stalls = 0;
      calm        = 1'b0;
      held        = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      fork
         run_sender();
         run_receiver();
      join_any
      while (tracker.waiting() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d compressed beats in %0d streams, %0d decoded beats checked,",
               n_beats, n_streams, tracker.checked);
      $display("input held off by full for %0d cycles", full_stalls);
      if (tracker.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/lzss_pkg.sv
rtl/lzss_fifo.sv
rtl/lzss_front.sv
rtl/lzss_back.sv
rtl/lzss_stream_decoder.sv
dv/testbench.sv
